[rtl/nlp_pkg.sv]
`timescale 1ns / 1ps

package nlp_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned NarrowBits = 8;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned DigitBits  = 6;
  localparam int unsigned RadixBits  = 5;
  localparam int unsigned OutBytes   = (ValueBits + StatusBits + 7) / 8;

  localparam logic [1:0] KindWord  = 2'd0;
  localparam logic [1:0] KindByte  = 2'd1;
  localparam logic [1:0] KindReg   = 2'd2;
  localparam logic [1:0] KindSpare = 2'd3;

  localparam logic [StatusBits-1:0] ErrNone     = 2'd0;
  localparam logic [StatusBits-1:0] ErrInvalid  = 2'd1;
  localparam logic [StatusBits-1:0] ErrFraction = 2'd2;

  localparam logic [1:0] PosStart  = 2'd0;
  localparam logic [1:0] PosSign   = 2'd1;
  localparam logic [1:0] PosSecond = 2'd2;
  localparam logic [1:0] PosBody   = 2'd3;

  localparam logic [RadixBits-1:0] RadixBin = 5'd2;
  localparam logic [RadixBits-1:0] RadixDec = 5'd10;
  localparam logic [RadixBits-1:0] RadixHex = 5'd16;

  localparam logic [DigitBits-1:0] DigitNone = 6'd36;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;
  localparam logic [7:0] CharHex   = 8'h78;
  localparam logic [7:0] CharBin   = 8'h62;
  localparam logic [7:0] CharDec   = 8'h64;

  function automatic logic [DigitBits-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(DigitNone);
    if (c inside {[CharZero:CharNine]}) begin
      d = c - CharZero;
    end else if (c inside {[CharUpA:CharUpZ]}) begin
      d = c - CharUpA + 8'd10;
    end else if (c inside {[CharLoA:CharLoZ]}) begin
      d = c - CharLoA + 8'd10;
    end
    return d[DigitBits-1:0];
  endfunction

endpackage

[rtl/numeric_literal_parser_unit.sv]
`timescale 1ns / 1ps

// Output: a result is registered onto m_axis in the cycle after its tlast is accepted.
// Throughput: one character per cycle while no result waits with m_axis_tready low;
// each character is one shift-add pass on the token state; tlast loads the result.
// Reset: rst_ni clears the token state to its start (radix ten) and empties the
// result register; the state also returns to its start after every last character.
module numeric_literal_parser_unit #(
  parameter int unsigned WORD_BITS = nlp_pkg::WordBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // ch
  input  logic                           s_axis_tlast,  // last
  input  logic [1:0]                     s_axis_tuser,  // req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [nlp_pkg::OutBytes*8-1:0] m_axis_tdata   // value, status, zero fill
);

  localparam int unsigned ExtBits = (WORD_BITS > nlp_pkg::ValueBits) ?
                                    WORD_BITS : nlp_pkg::ValueBits;
  localparam int unsigned PadBits = nlp_pkg::OutBytes * 8 - nlp_pkg::ValueBits
                                    - nlp_pkg::StatusBits;

  logic [1:0]                      pos_q, pos_d;
  logic [nlp_pkg::RadixBits-1:0]   radix_q, radix_d;
  logic [WORD_BITS-1:0]            acc_q, acc_d;
  logic                            neg_q, neg_d;
  logic [nlp_pkg::StatusBits-1:0]  err_q, err_d;
  logic                            fdz_q, fdz_d;

  logic                            out_valid_q;
  logic [nlp_pkg::ValueBits-1:0]   out_value_q, out_value_d;
  logic [nlp_pkg::StatusBits-1:0]  out_status_q, out_status_d;

  logic                            accept;
  logic [1:0]                      kind;
  logic [nlp_pkg::DigitBits-1:0]   digit;
  logic                            bad_digit;
  logic                            is_dec;
  logic [WORD_BITS-1:0]            acc_scaled;
  logic [nlp_pkg::StatusBits-1:0]  body_err;
  logic [WORD_BITS-1:0]            body_acc;
  logic [1:0]                      step_pos;
  logic [nlp_pkg::RadixBits-1:0]   step_radix;
  logic [WORD_BITS-1:0]            step_acc;
  logic                            step_neg;
  logic [nlp_pkg::StatusBits-1:0]  step_err;
  logic                            step_fdz;
  logic [WORD_BITS-1:0]            signed_val;
  logic [WORD_BITS-1:0]            masked_val;
  logic [ExtBits-1:0]              ext_val;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign kind      = (s_axis_tuser == nlp_pkg::KindSpare) ? nlp_pkg::KindReg : s_axis_tuser;
  assign digit     = nlp_pkg::digit_of(s_axis_tdata);
  assign bad_digit = digit >= {1'b0, radix_q};
  assign is_dec    = s_axis_tdata inside {[nlp_pkg::CharZero:nlp_pkg::CharNine]};

  always_comb begin
    case (radix_q)
      nlp_pkg::RadixHex: acc_scaled = acc_q << 4;
      nlp_pkg::RadixBin: acc_scaled = acc_q << 1;
      default:           acc_scaled = (acc_q << 3) + (acc_q << 1);
    endcase
  end

  always_comb begin
    body_err = err_q;
    body_acc = acc_q;
    if (err_q == nlp_pkg::ErrInvalid) begin
      body_err = err_q;
    end else if (err_q == nlp_pkg::ErrFraction) begin
      if (bad_digit) body_err = nlp_pkg::ErrInvalid;
    end else if (s_axis_tdata == nlp_pkg::CharDot) begin
      body_err = (kind == nlp_pkg::KindWord) ? nlp_pkg::ErrFraction : nlp_pkg::ErrInvalid;
    end else if (bad_digit) begin
      body_err = nlp_pkg::ErrInvalid;
    end else begin
      body_acc = acc_scaled + WORD_BITS'(digit);
    end
  end

  always_comb begin
    step_pos   = pos_q;
    step_radix = radix_q;
    step_acc   = acc_q;
    step_neg   = neg_q;
    step_err   = err_q;
    step_fdz   = fdz_q;
    if (pos_q == nlp_pkg::PosStart && s_axis_tdata == nlp_pkg::CharMinus) begin
      if (kind == nlp_pkg::KindReg) step_err = nlp_pkg::ErrInvalid;
      else step_neg = 1'b1;
      step_pos = nlp_pkg::PosSign;
    end else if (pos_q == nlp_pkg::PosStart || pos_q == nlp_pkg::PosSign) begin
      step_fdz = s_axis_tdata == nlp_pkg::CharZero;
      step_err = body_err;
      step_acc = body_acc;
      step_pos = nlp_pkg::PosSecond;
    end else if (pos_q == nlp_pkg::PosSecond) begin
      if (fdz_q && !is_dec && s_axis_tdata != nlp_pkg::CharDot && !s_axis_tlast) begin
        if (err_q == nlp_pkg::ErrNone) begin
          case (s_axis_tdata)
            nlp_pkg::CharHex: step_radix = nlp_pkg::RadixHex;
            nlp_pkg::CharBin: step_radix = nlp_pkg::RadixBin;
            nlp_pkg::CharDec: step_radix = nlp_pkg::RadixDec;
            default:          step_err   = nlp_pkg::ErrInvalid;
          endcase
        end
      end else begin
        step_err = body_err;
        step_acc = body_acc;
      end
      step_pos = nlp_pkg::PosBody;
    end else begin
      step_err = body_err;
      step_acc = body_acc;
    end
  end

  assign signed_val = step_neg ? (WORD_BITS'(0) - step_acc) : step_acc;
  assign masked_val = (kind == nlp_pkg::KindWord) ? signed_val :
                      WORD_BITS'(signed_val[nlp_pkg::NarrowBits-1:0]);
  assign ext_val    = ExtBits'(masked_val);

  always_comb begin
    out_status_d = step_err;
    out_value_d  = (step_err != nlp_pkg::ErrNone) ? '0 :
                   ext_val[nlp_pkg::ValueBits-1:0];
  end

  always_comb begin
    pos_d   = pos_q;
    radix_d = radix_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    err_d   = err_q;
    fdz_d   = fdz_q;
    if (accept) begin
      if (s_axis_tlast) begin
        pos_d   = nlp_pkg::PosStart;
        radix_d = nlp_pkg::RadixDec;
        acc_d   = '0;
        neg_d   = 1'b0;
        err_d   = nlp_pkg::ErrNone;
        fdz_d   = 1'b0;
      end else begin
        pos_d   = step_pos;
        radix_d = step_radix;
        acc_d   = step_acc;
        neg_d   = step_neg;
        err_d   = step_err;
        fdz_d   = step_fdz;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= nlp_pkg::PosStart;
      radix_q <= nlp_pkg::RadixDec;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      err_q   <= nlp_pkg::ErrNone;
      fdz_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      radix_q <= radix_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      err_q   <= err_d;
      fdz_q   <= fdz_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tlast) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {PadBits'(0), out_status_q, out_value_q};

`ifndef SYNTHESIS
  a_error_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_status_q != nlp_pkg::ErrNone |-> out_value_q == '0)
    else $error("error result carries a nonzero value");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast |=> pos_q == nlp_pkg::PosStart && acc_q == '0
                               && radix_q == nlp_pkg::RadixDec)
    else $error("token state not restarted after last character");

  a_radix_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    radix_q == nlp_pkg::RadixBin || radix_q == nlp_pkg::RadixDec
    || radix_q == nlp_pkg::RadixHex)
    else $error("illegal radix");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == nlp_pkg::PosStart |-> err_q == nlp_pkg::ErrNone && !neg_q && !fdz_q)
    else $error("stale token state at token start");
`endif

endmodule
